// ===== rtl/lcm_pkg.sv =====
// Shared types and constants for the least common multiple unit.
package lcm_pkg;

  // Width of the result field.
  localparam int MULTIPLE_BITS = 62;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } lcm_state_t;

  // Datapath operations issued by the sequencer, one per cycle.
  typedef enum logic [2:0] {
    DP_HOLD,
    DP_LOAD,
    DP_TWOS,
    DP_GCD,
    DP_SCALE,
    DP_DIV,
    DP_MUL
  } lcm_op_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    lcm_op_t op;
  } lcm_ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic u_odd;
    logic v_odd;
    logic u_eq_v;
  } lcm_status_t;

endpackage

// ===== rtl/lcm_alu.sv =====
// Shared add/subtract unit used by the gcd subtraction, division and multiplication steps of the datapath.
module lcm_alu import lcm_pkg::*; #(
  parameter int OPERAND_BITS = 31
) (
  input  logic [OPERAND_BITS:0] op_a,
  input  logic [OPERAND_BITS:0] op_b,
  input  logic                  subtract,
  output logic [OPERAND_BITS:0] sum,
  output logic                  borrow
);

  localparam int AW = OPERAND_BITS + 2;

  logic [AW-1:0] full_sum;
  logic [OPERAND_BITS:0] op_b_eff;

  // Subtraction is done as addition of the inverted operand plus one.
  assign op_b_eff = subtract ? ~op_b : op_b;
  assign full_sum = {1'b0, op_a} + {1'b0, op_b_eff} + AW'(subtract);
  assign sum      = full_sum[OPERAND_BITS:0];
  assign borrow   = subtract & ~full_sum[AW-1];

endmodule

// ===== rtl/lcm_dp.sv =====
// Datapath registers of the least common multiple unit around the shared adder.
module lcm_dp import lcm_pkg::*; #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                      clk,
  input  lcm_ctrl_t                 ctrl,
  input  logic [OPERAND_BITS-1:0]   first_in,
  input  logic [OPERAND_BITS-1:0]   second_in,
  output lcm_status_t               status,
  output logic [2*OPERAND_BITS-1:0] product,
  output logic                      zero_flag
);

  localparam int KW = $clog2(OPERAND_BITS);

  logic [OPERAND_BITS-1:0] a_reg;
  logic [OPERAND_BITS-1:0] b_reg;
  logic [OPERAND_BITS-1:0] u;
  logic [OPERAND_BITS-1:0] v;
  logic [KW-1:0]           k;
  logic [OPERAND_BITS:0]   shifted_rem;
  logic [OPERAND_BITS:0]   alu_a;
  logic [OPERAND_BITS:0]   alu_b;
  logic                    alu_sub;
  logic [OPERAND_BITS:0]   alu_sum;
  logic                    alu_borrow;
  logic                    u_ge_v;

  // Partial remainder with the next dividend bit shifted in.
  assign shifted_rem = {u, a_reg[OPERAND_BITS-1]};
  assign u_ge_v      = (u >= v);

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.op)
      DP_GCD: begin
        alu_sub = 1'b1;
        if (u_ge_v) begin
          alu_a = {1'b0, u};
          alu_b = {1'b0, v};
        end else begin
          alu_a = {1'b0, v};
          alu_b = {1'b0, u};
        end
      end
      DP_DIV: begin
        alu_sub = 1'b1;
        alu_a   = shifted_rem;
        alu_b   = {1'b0, v};
      end
      DP_MUL: begin
        alu_a = {1'b0, u};
        alu_b = a_reg[0] ? {1'b0, b_reg} : '0;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  lcm_alu #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_alu (
    .op_a    (alu_a),
    .op_b    (alu_b),
    .subtract(alu_sub),
    .sum     (alu_sum),
    .borrow  (alu_borrow)
  );

  // Register updates for each step. The gcd is found by the binary method:
  // common factors of two are counted in k, the odd part is left in v, and
  // v is then scaled back up. Division leaves the quotient in a_reg and a
  // zero remainder in u, which then serve as the low and high product halves.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_LOAD: begin
        a_reg     <= first_in;
        b_reg     <= second_in;
        u         <= first_in;
        v         <= second_in;
        k         <= '0;
        zero_flag <= (first_in == '0) || (second_in == '0);
      end
      DP_TWOS: begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + KW'(1);
      end
      DP_GCD: begin
        if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u_ge_v) begin
          u <= alu_sum[OPERAND_BITS-1:0];
        end else begin
          v <= alu_sum[OPERAND_BITS-1:0];
        end
      end
      DP_SCALE: begin
        v <= v << k;
        u <= '0;
      end
      DP_DIV: begin
        if (alu_borrow) begin
          u <= shifted_rem[OPERAND_BITS-1:0];
        end else begin
          u <= alu_sum[OPERAND_BITS-1:0];
        end
        a_reg <= {a_reg[OPERAND_BITS-2:0], ~alu_borrow};
      end
      DP_MUL: begin
        u     <= alu_sum[OPERAND_BITS:1];
        a_reg <= {alu_sum[0], a_reg[OPERAND_BITS-1:1]};
      end
      default: begin
        u <= u;
      end
    endcase
  end

  assign status.u_odd  = u[0];
  assign status.v_odd  = v[0];
  assign status.u_eq_v = (u == v);
  assign product       = {u, a_reg};

endmodule

// ===== rtl/lcm_seq.sv =====
// Sequencer that steps the datapath through gcd, division and multiplication.
module lcm_seq import lcm_pkg::*; #(
  parameter int OPERAND_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        zero_in,
  input  logic        out_free,
  input  lcm_status_t status,
  output lcm_ctrl_t   ctrl,
  output logic        idle,
  output logic        done_load
);

  localparam int CW = $clog2(OPERAND_BITS);

  lcm_state_t    state;
  lcm_state_t    state_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl.op    = DP_HOLD;
    idle       = 1'b0;
    done_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          ctrl.op    = DP_LOAD;
          state_next = zero_in ? ST_DONE : ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (status.u_odd || status.v_odd) begin
          state_next = ST_GCD;
        end else begin
          ctrl.op = DP_TWOS;
        end
      end
      ST_GCD: begin
        if (status.u_eq_v) begin
          state_next = ST_SCALE;
        end else begin
          ctrl.op = DP_GCD;
        end
      end
      ST_SCALE: begin
        ctrl.op    = DP_SCALE;
        cnt_next   = CW'(OPERAND_BITS - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        ctrl.op = DP_DIV;
        if (cnt == '0) begin
          cnt_next   = CW'(OPERAND_BITS - 1);
          state_next = ST_MUL;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      ST_MUL: begin
        ctrl.op = DP_MUL;
        if (cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/least_common_multiple_unit.sv =====
// Top level of the least common multiple unit: handshakes, sequencer and datapath.
//
// The unit takes one pair of operands at a time and returns their least common
// multiple, computed as (first / gcd) * second. All additions and subtractions
// run through one shared adder of OPERAND_BITS+1 bits, one step per cycle: the
// binary gcd shifts out common factors of two, then shifts or subtracts until
// both values match; the gcd is then scaled back up by the common factors of
// two, and a restoring division and a shift-add multiplication follow, before
// the result is handed off to the output register. If either operand is zero
// the result is zero with zero_operand set, and the computation is skipped.
// A finished result waits in an output register, and the next pair may be
// taken in while it does.
module least_common_multiple_unit import lcm_pkg::*; #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPERAND_BITS-1:0]  first_operand,
  input  logic [OPERAND_BITS-1:0]  second_operand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MULTIPLE_BITS-1:0] multiple,
  output logic                     zero_operand
);

  localparam int PW = 2 * OPERAND_BITS;
  localparam int MW = (PW > MULTIPLE_BITS) ? PW : MULTIPLE_BITS;

  lcm_ctrl_t   ctrl;
  lcm_status_t status;
  logic        start;
  logic        zero_in;
  logic        out_free;
  logic        done_load;
  logic        zero_flag;
  logic [PW-1:0] product;
  logic [MW-1:0] product_ext;

  assign start    = in_valid & in_ready;
  assign zero_in  = (first_operand == '0) || (second_operand == '0);
  assign out_free = ~out_valid | out_ready;

  lcm_seq #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .zero_in  (zero_in),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (in_ready),
    .done_load(done_load)
  );

  lcm_dp #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .first_in (first_operand),
    .second_in(second_operand),
    .status   (status),
    .product  (product),
    .zero_flag(zero_flag)
  );

  // The result field keeps the low bits of the product.
  assign product_ext = MW'(product);

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (done_load) begin
      multiple     <= zero_flag ? '0 : product_ext[MULTIPLE_BITS-1:0];
      zero_operand <= zero_flag;
    end
  end

endmodule
